// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with and without a reset qualifier; empty in
// synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every rising edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// check a property on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: hdl/mkdef_pkg.sv
// ---------------------------------------------------------------------------
// mkdef_pkg
// Shared types and constants of the key debounce and event queue block.
// ---------------------------------------------------------------------------
`default_nettype none

package mkdef_pkg;

    // field widths
    localparam int OP_W      = 2;
    localparam int KEYS_W    = 8;
    localparam int SEL_W     = 3;
    localparam int CODE_W    = 5;
    localparam int FILTER_W  = 7;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE  = 2'd1;

    // reset values
    localparam int                    RESET_FILTER_INT = 5;
    localparam logic [FILTER_W-1:0]   RESET_FILTER     = FILTER_W'(RESET_FILTER_INT);
    localparam logic [COUNT_W-1:0]    RESET_COUNT      = COUNT_W'(RESET_FILTER_INT / 2);
    localparam logic [KEYS_W-1:0]     RESET_ENABLE     = 8'h01;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;    // latch the incoming word
        logic clear;     // empty the ring
        logic visit;     // debounce the key at the key index
        logic pop;       // read the oldest code
        logic load_out;  // load the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

// File: hdl/multi_key_debounce_event_fifo_unit.sv
// ---------------------------------------------------------------------------
// multi_key_debounce_event_fifo_unit
// Counter debounce of up to eight keys with a ring of press/release codes.
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         i_valid / o_stall      i_op, i_key_down, i_key_select
//  result    out        o_valid / i_stall      o_key_code, o_key_states,
//                                              o_selected_state, o_queue_empty
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  A scan tick walks the keys one key a cycle through the shared debounce
//  update, between the accept and the result load. A pop passes through its
//  own state (the ring memory read is registered); a clear or unused op goes from accept to result load.
//  Reset is synchronous; no clearing pass, the ring needs no initial contents.
//  A new word is taken while the previous result still waits under i_stall;
//  only the result load waits for the output register to free up.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_key_debounce_event_fifo_unit
    import mkdef_pkg::*;
#(
    parameter int NUM_KEYS    = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [KEYS_W-1:0]    i_key_down,
    input  wire logic [SEL_W-1:0]     i_key_select,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [CODE_W-1:0]         o_key_code,
    output logic [KEYS_W-1:0]         o_key_states,
    output logic                      o_selected_state,
    output logic                      o_queue_empty,
    // configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_dp_cmd          cmd;
    logic [KEY_W-1:0] key;

    assign o_cfg_ready = 1'b1;

    mkdef_ctrl #(
        .NUM_KEYS (NUM_KEYS),
        .KEY_W    (KEY_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .o_key   (key)
    );

    mkdef_dp #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_W       (KEY_W),
        .PTR_W       (PTR_W)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_key            (key),
        .i_op             (i_op),
        .i_key_down       (i_key_down),
        .i_key_select     (i_key_select),
        .i_cfg_write      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_key_code       (o_key_code),
        .o_key_states     (o_key_states),
        .o_selected_state (o_selected_state),
        .o_queue_empty    (o_queue_empty)
    );

endmodule

`default_nettype wire

// File: hdl/mkdef_ctrl.sv
// ---------------------------------------------------------------------------
// mkdef_ctrl
// Sequencer: accepts one word, walks the keys on a tick, issues the pop or
// clear, then loads the result register when it is free.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mkdef_ctrl
    import mkdef_pkg::*;
#(
    parameter int NUM_KEYS = 8,
    parameter int KEY_W    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [OP_W-1:0]  i_op,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_dp_cmd               o_cmd,
    output logic [KEY_W-1:0]      o_key
);

    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_FINISH
    } t_state;

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic             r_out_valid, n_out_valid;
    logic             accept;
    logic             out_free;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_key        = '0;
                    case (i_op)
                        OP_TICK:  n_state = S_SCAN;
                        OP_POP:   n_state = S_POP;
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_FINISH;
                        end
                        default:  n_state = S_FINISH;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.visit = 1'b1;
                if (r_key == LAST_KEY) begin
                    n_state = S_FINISH;
                end else begin
                    n_key = r_key + 1'b1;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_key   = r_key;

    `ASSERT_CLK(a_valid_from_finish, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
    `ASSERT_CLK(a_pop_follows_accept, i_clk, i_rst_n,
        (accept && i_op == OP_POP) |=> (r_state == S_POP))
    `ASSERT_CLK(a_key_in_range, i_clk, i_rst_n,
        (r_state == S_SCAN) |-> (r_key <= LAST_KEY))
    `ASSERT_CLK(a_finish_waits, i_clk, i_rst_n,
        (r_state == S_FINISH && r_out_valid && i_stall) |=> (r_state == S_FINISH))

endmodule

`default_nettype wire

// File: hdl/mkdef_dp.sv
// ---------------------------------------------------------------------------
// mkdef_dp
// Datapath: configuration registers, per-key debounce counters and states,
// event ring memory with its positions, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mkdef_dp
    import mkdef_pkg::*;
#(
    parameter int NUM_KEYS    = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_W       = 3,
    parameter int PTR_W       = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic [KEY_W-1:0]     i_key,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [KEYS_W-1:0]    i_key_down,
    input  wire logic [SEL_W-1:0]     i_key_select,
    input  wire logic                 i_cfg_write,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic [CODE_W-1:0]         o_key_code,
    output logic [KEYS_W-1:0]         o_key_states,
    output logic                      o_selected_state,
    output logic                      o_queue_empty
);

    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(QUEUE_DEPTH - 1);

    // configuration
    logic [FILTER_W-1:0] r_filter;
    logic [KEYS_W-1:0]   r_enable;

    // latched word
    logic [OP_W-1:0]     r_op;
    logic [KEYS_W-1:0]   r_key_down;
    logic [SEL_W-1:0]    r_key_select;

    // debounce state
    logic [COUNT_W-1:0]  r_count [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_state;

    // ring
    logic [CODE_W-1:0]   r_ring [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_rd_pos, r_wr_pos;
    logic [CODE_W-1:0]   r_rd_data;
    logic                r_pop_hit;

    // visit unit
    logic [COUNT_W-1:0]  cur_count, n_count;
    logic                cur_state, n_state_bit;
    logic                push;
    logic [CODE_W-1:0]   push_code;
    logic [COUNT_W-1:0]  ft, top;
    logic                enabled;
    logic                ring_empty;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    assign ft         = {1'b0, r_filter};
    assign top        = {r_filter, 1'b0};
    assign cur_count  = r_count[i_key];
    assign cur_state  = r_state[i_key];
    assign enabled    = r_enable[i_key];
    assign ring_empty = (r_rd_pos == r_wr_pos);

    // debounce one key
    always_comb begin
        n_count     = cur_count;
        n_state_bit = cur_state;
        push        = 1'b0;
        push_code   = CODE_W'({i_key, 1'b0}) + CODE_W'(1);
        if (r_key_down[i_key]) begin
            if (cur_count < ft) begin
                n_count = ft;
            end else if (cur_count < top) begin
                n_count = cur_count + 1'b1;
            end else if (!cur_state) begin
                n_state_bit = 1'b1;
                push        = 1'b1;
            end
        end else begin
            push_code = CODE_W'({i_key, 1'b0}) + CODE_W'(2);
            if (cur_count > ft) begin
                n_count = ft;
            end else if (cur_count != '0) begin
                n_count = cur_count - 1'b1;
            end else if (cur_state) begin
                n_state_bit = 1'b0;
                push        = 1'b1;
            end
        end
    end

    // hold configuration, counters, states and positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter  <= RESET_FILTER;
            r_enable  <= RESET_ENABLE;
            r_state   <= '0;
            r_rd_pos  <= '0;
            r_wr_pos  <= '0;
            r_pop_hit <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_count[k] <= RESET_COUNT;
            end
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    CFG_FILTER_TIME: r_filter <= i_cfg_data[FILTER_W-1:0];
                    CFG_KEY_ENABLE:  r_enable <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.visit && enabled) begin
                r_count[i_key] <= n_count;
                r_state[i_key] <= n_state_bit;
                if (push) begin
                    r_wr_pos <= ptr_next(r_wr_pos);
                end
            end
            if (i_cmd.clear) begin
                r_rd_pos <= r_wr_pos;
            end
            if (i_cmd.pop) begin
                r_pop_hit <= !ring_empty;
                if (!ring_empty) begin
                    r_rd_pos <= ptr_next(r_rd_pos);
                end
            end
        end
    end

    // write and read the ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.visit && enabled && push) begin
            r_ring[r_wr_pos] <= push_code;
        end
        if (i_cmd.pop) begin
            r_rd_data <= r_ring[r_rd_pos];
        end
    end

    // latch the word and load the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op         <= i_op;
            r_key_down   <= i_key_down;
            r_key_select <= i_key_select;
        end
        if (i_cmd.load_out) begin
            o_key_code    <= (r_op == OP_POP && r_pop_hit) ? r_rd_data : '0;
            o_key_states  <= KEYS_W'(r_state);
            o_queue_empty <= ring_empty;
            if (32'(r_key_select) < NUM_KEYS) begin
                o_selected_state <= r_state[r_key_select[KEY_W-1:0]];
            end else begin
                o_selected_state <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
